[rtl/gbts_pkg.sv]
// ---------------------------------------------------------------------------
// gbts_pkg
// Shared types and constants for the gap buffer text store.
// ---------------------------------------------------------------------------
package gbts_pkg;

    localparam int CAPACITY_DEF = 256;

    typedef enum logic [2:0] {
        CMD_INSERT    = 3'd0,
        CMD_BACKSPACE = 3'd1,
        CMD_FORWARD   = 3'd2,
        CMD_BACK      = 3'd3,
        CMD_TO_START  = 3'd4,
        CMD_TO_END    = 3'd5,
        CMD_READ      = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EDGE  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_RDW,
        S_DONE
    } t_state;

endpackage

[rtl/gbts_ram.sv]
// ---------------------------------------------------------------------------
// gbts_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module gbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/gap_buffer_text_store.sv]
// ---------------------------------------------------------------------------
// gap_buffer_text_store
// Text store of CAPACITY bytes kept as two stacks in one RAM around a cursor.
// ---------------------------------------------------------------------------
// One command is in flight at a time. Insert, backspace, unused codes and
// every command that hits an edge, is full or is out of range go straight
// from accept to the done state; read waits on the registered RAM read, and
// forward and back pass through the move state. To start and to end move
// one byte per cycle through the single RAM read and write ports, up to the
// edge (at most CAPACITY bytes). The result sits in an output register; a
// stalled result holds the block before its next accept. Entries that were
// never written are not cleared; reads only reach written text.
module gap_buffer_text_store #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_ch,
    input  logic [7:0] i_position,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_char_out,
    output logic [8:0] o_cursor,
    output logic [8:0] o_length,
    output logic [1:0] o_status
);

    import gbts_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 8;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_bc, n_bc;
    logic [CW-1:0]   r_as, n_as;
    logic            r_fwd, n_fwd;
    logic            r_walk, n_walk;
    t_status         r_status, n_status;
    logic [7:0]      r_char, n_char;
    logic            r_ovalid, n_ovalid;
    logic [7:0]      r_ochar, n_ochar;
    logic [8:0]      r_ocursor, n_ocursor;
    logic [8:0]      r_olength, n_olength;
    logic [1:0]      r_ostatus, n_ostatus;

    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [7:0]      mem_wdata, mem_rdata;

    logic [CW-1:0]   len, bc_m1, bc_m2, as_m1, as_p1;
    logic [XW-1:0]   pos_x, tail_x;
    logic            accept, slot_free;

    gbts_ram #(
        .WIDTH(8),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign len    = r_bc + (CAP_C - r_as);
    assign bc_m1  = r_bc - CW'(1);
    assign bc_m2  = r_bc - CW'(2);
    assign as_m1  = r_as - CW'(1);
    assign as_p1  = r_as + CW'(1);
    assign pos_x  = XW'(i_position);
    assign tail_x = XW'(r_as) + pos_x - XW'(r_bc);

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign slot_free  = !r_ovalid || i_out_ready;

    always_comb begin
        n_state   = r_state;
        n_bc      = r_bc;
        n_as      = r_as;
        n_fwd     = r_fwd;
        n_walk    = r_walk;
        n_status  = r_status;
        n_char    = r_char;
        n_ovalid  = r_ovalid;
        n_ochar   = r_ochar;
        n_ocursor = r_ocursor;
        n_olength = r_olength;
        n_ostatus = r_ostatus;
        mem_we    = 1'b0;
        mem_waddr = r_bc[AW-1:0];
        mem_wdata = i_ch;
        mem_re    = 1'b0;
        mem_raddr = r_as[AW-1:0];

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_char   = 8'd0;
                    n_state  = S_DONE;
                    unique case (t_cmd'(i_cmd))
                        CMD_INSERT: begin
                            if (r_bc >= r_as) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we = 1'b1;
                                n_bc   = r_bc + CW'(1);
                            end
                        end
                        CMD_BACKSPACE: begin
                            if (r_bc == '0) begin
                                n_status = ST_EDGE;
                            end else begin
                                n_bc = bc_m1;
                            end
                        end
                        CMD_FORWARD, CMD_TO_END: begin
                            if (r_as == CAP_C) begin
                                n_status = ST_EDGE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_as[AW-1:0];
                                n_fwd     = 1'b1;
                                n_walk    = (t_cmd'(i_cmd) == CMD_TO_END);
                                n_state   = S_MOVE;
                            end
                        end
                        CMD_BACK, CMD_TO_START: begin
                            if (r_bc == '0) begin
                                n_status = ST_EDGE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = bc_m1[AW-1:0];
                                n_fwd     = 1'b0;
                                n_walk    = (t_cmd'(i_cmd) == CMD_TO_START);
                                n_state   = S_MOVE;
                            end
                        end
                        CMD_READ: begin
                            if (pos_x >= XW'(len)) begin
                                n_status = ST_RANGE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = (pos_x < XW'(r_bc)) ? pos_x[AW-1:0]
                                                                : tail_x[AW-1:0];
                                n_state   = S_RDW;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MOVE: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                n_state   = S_DONE;
                if (r_fwd) begin
                    mem_waddr = r_bc[AW-1:0];
                    n_bc      = r_bc + CW'(1);
                    n_as      = as_p1;
                    if (r_walk && (as_p1 != CAP_C)) begin
                        mem_re    = 1'b1;
                        mem_raddr = as_p1[AW-1:0];
                        n_state   = S_MOVE;
                    end
                end else begin
                    mem_waddr = as_m1[AW-1:0];
                    n_bc      = bc_m1;
                    n_as      = as_m1;
                    if (r_walk && (bc_m1 != '0)) begin
                        mem_re    = 1'b1;
                        mem_raddr = bc_m2[AW-1:0];
                        n_state   = S_MOVE;
                    end
                end
            end
            S_RDW: begin
                n_char  = mem_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    n_ovalid  = 1'b1;
                    n_ochar   = r_char;
                    n_ocursor = 9'(r_bc);
                    n_olength = 9'(len);
                    n_ostatus = r_status;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bc     <= '0;
            r_as     <= CAP_C;
            r_ovalid <= 1'b0;
            r_fwd    <= 1'b0;
            r_walk   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bc     <= n_bc;
            r_as     <= n_as;
            r_ovalid <= n_ovalid;
            r_fwd    <= n_fwd;
            r_walk   <= n_walk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_char    <= n_char;
        r_ochar   <= n_ochar;
        r_ocursor <= n_ocursor;
        r_olength <= n_olength;
        r_ostatus <= n_ostatus;
    end

    assign o_out_valid = r_ovalid;
    assign o_char_out  = r_ochar;
    assign o_cursor    = r_ocursor;
    assign o_length    = r_olength;
    assign o_status    = r_ostatus;

endmodule
